FILE: rtl/ipp_pkg.sv
// ipp_pkg: shared types and codes for the instance pair picker.
// Holds the input and result structs, life-state, function and register codes.
// No dependencies.
package ipp_pkg;

    localparam int MASK_W = 16;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    // life states
    localparam logic [1:0] ST_SLEEP = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_AWAKE = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    // function codes
    localparam logic [1:0] FN_SET  = 2'd0;
    localparam logic [1:0] FN_PICK = 2'd1;
    localparam logic [1:0] FN_READ = 2'd2;

    // configuration register indexes
    localparam logic REG_PREFILL_MASK = 1'b0;
    localparam logic REG_DECODE_MASK  = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] slot;
        logic [1:0] req_state;
    } in_t;

    typedef struct packed {
        logic             ok;
        logic [3:0]       prefill_slot;
        logic [3:0]       decode_slot;
        logic [1:0]       slot_status;
        logic [CNT_W-1:0] awake_count;
        logic [CNT_W-1:0] allocated_count;
        logic             waking_up;
    } out_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

endpackage

FILE: rtl/instance_pair_picker.sv
// instance_pair_picker: top level, joins ipp_controller and ipp_datapath.
// Uses ipp_pkg for payload types.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------
//  request  | start / busy            | item   (ipp_pkg::in_t)
//  result   | done (one-cycle strobe) | result (ipp_pkg::out_t)
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Every transaction is captured, then executed; the execute step is where
// both rotated priority encoders run over the awake and role vectors.
// done pulses the cycle after execute; a new request may be taken in that cycle.
// Reset clears all slots to sleep, pointers, counters and masks at once.
// The result side cannot stall; cfg_ready is always high.
module instance_pair_picker #(
    parameter int SLOTS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ipp_pkg::in_t               item,
    output logic                       done,
    output ipp_pkg::out_t              result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [ipp_pkg::MASK_W-1:0] cfg_data
);

    ipp_pkg::ctrl_t cmd;

    assign cfg_ready = 1'b1;

    ipp_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    ipp_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

FILE: rtl/ipp_controller.sv
// ipp_controller: two-state sequencer for the instance pair picker.
// Issues capture/execute commands and the result strobe. Uses ipp_pkg.
module ipp_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output ipp_pkg::ctrl_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign busy        = (state_reg == S_EXEC);
    assign done        = done_reg;
    assign cmd.capture = start && (state_reg == S_IDLE);
    assign cmd.execute = (state_reg == S_EXEC);

endmodule

FILE: rtl/ipp_datapath.sv
// ipp_datapath: slot life states, counters, role masks and round-robin search.
// Driven by ipp_controller commands. Uses ipp_pkg.
module ipp_datapath #(
    parameter int SLOTS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ipp_pkg::ctrl_t             cmd,
    input  ipp_pkg::in_t               item,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ipp_pkg::MASK_W-1:0] cfg_data,
    output ipp_pkg::out_t              result
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = ipp_pkg::CNT_W;

    ipp_pkg::in_t  item_reg;
    ipp_pkg::out_t result_reg;
    ipp_pkg::out_t result_next;

    logic [ipp_pkg::MASK_W-1:0] prefill_mask_reg;
    logic [ipp_pkg::MASK_W-1:0] decode_mask_reg;
    logic [1:0]    life_reg [SLOTS];
    logic [SW-1:0] p_ptr_reg;
    logic [SW-1:0] p_ptr_next;
    logic [SW-1:0] d_ptr_reg;
    logic [SW-1:0] d_ptr_next;
    logic [CW-1:0] awake_reg;
    logic [CW-1:0] awake_next;
    logic [CW-1:0] alloc_reg;
    logic [CW-1:0] alloc_next;

    logic [SLOTS-1:0] p_mem;
    logic [SLOTS-1:0] d_mem;
    logic [SLOTS-1:0] awake_vec;
    logic [SLOTS-1:0] p_geq;
    logic [SLOTS-1:0] d_geq;
    logic [SLOTS-1:0] p_elig;
    logic [SLOTS-1:0] d_elig;

    logic [SW-1:0] slot_idx;
    logic          in_range;
    logic [1:0]    cur;
    logic          set_ok;
    logic          life_we;
    logic [SW-1:0] p_hit;
    logic [SW-1:0] d_hit;
    logic          p_found;
    logic          d_found;

    function automatic logic [SW-1:0] first_set(input logic [SLOTS-1:0] v);
        logic [SW-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] rr_pick(input logic [SLOTS-1:0] elig,
                                              input logic [SLOTS-1:0] geq);
        logic [SLOTS-1:0] hi;
        hi = elig & geq;
        return (|hi) ? first_set(hi) : first_set(elig);
    endfunction

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
        return (p == SW'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c == ipp_pkg::CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CW-1:0] sat_dec(input logic [CW-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_slot
            if (g < ipp_pkg::MASK_W)
            begin : g_mask
                assign p_mem[g] = prefill_mask_reg[g];
                assign d_mem[g] = decode_mask_reg[g];
            end
            else
            begin : g_nomask
                assign p_mem[g] = 1'b0;
                assign d_mem[g] = 1'b0;
            end
            assign awake_vec[g] = (life_reg[g] == ipp_pkg::ST_AWAKE);
            assign p_geq[g]     = (32'(g) >= 32'(p_ptr_reg));
            assign d_geq[g]     = (32'(g) >= 32'(d_ptr_reg));
        end
    endgenerate

    assign p_elig   = p_mem & awake_vec;
    assign d_elig   = d_mem & awake_vec;
    assign p_found  = |p_elig;
    assign d_found  = |d_elig;
    assign p_hit    = rr_pick(p_elig, p_geq);
    assign d_hit    = rr_pick(d_elig, d_geq);

    assign slot_idx = SW'(item_reg.slot);
    assign in_range = (32'(item_reg.slot) < 32'(SLOTS));
    assign cur      = in_range ? life_reg[slot_idx] : ipp_pkg::ST_SLEEP;

    always_comb
    begin
        set_ok      = 1'b0;
        awake_next  = awake_reg;
        alloc_next  = alloc_reg;
        p_ptr_next  = p_ptr_reg;
        d_ptr_next  = d_ptr_reg;
        result_next = '0;

        unique case (item_reg.func)
            ipp_pkg::FN_SET:
            begin
                if (in_range)
                begin
                    case (item_reg.req_state)
                        ipp_pkg::ST_SLEEP:
                        begin
                            set_ok = 1'b1;
                            if (cur == ipp_pkg::ST_AWAKE)
                            begin
                                awake_next = sat_dec(awake_reg);
                                alloc_next = sat_dec(alloc_reg);
                            end
                            else if (cur == ipp_pkg::ST_ALLOC)
                            begin
                                alloc_next = sat_dec(alloc_reg);
                            end
                        end
                        ipp_pkg::ST_ALLOC:
                        begin
                            if (cur == ipp_pkg::ST_SLEEP)
                            begin
                                set_ok     = 1'b1;
                                alloc_next = sat_inc(alloc_reg);
                            end
                        end
                        ipp_pkg::ST_AWAKE:
                        begin
                            if (cur == ipp_pkg::ST_ALLOC)
                            begin
                                set_ok     = 1'b1;
                                awake_next = sat_inc(awake_reg);
                            end
                        end
                        default:
                        begin
                            if (cur == ipp_pkg::ST_AWAKE)
                            begin
                                set_ok     = 1'b1;
                                awake_next = sat_dec(awake_reg);
                                alloc_next = sat_dec(alloc_reg);
                            end
                        end
                    endcase
                end
            end
            ipp_pkg::FN_PICK:
            begin
                if ((|p_mem) && (|d_mem) && p_found)
                begin
                    if (d_found)
                    begin
                        result_next.ok           = 1'b1;
                        result_next.prefill_slot = 4'(p_hit);
                        result_next.decode_slot  = 4'(d_hit);
                        p_ptr_next               = wrap_inc(p_hit);
                        d_ptr_next               = wrap_inc(d_hit);
                    end
                    else
                    begin
                        p_ptr_next = p_hit;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (set_ok)
        begin
            result_next.ok = 1'b1;
        end
        result_next.slot_status     = set_ok ? item_reg.req_state : cur;
        result_next.awake_count     = awake_next;
        result_next.allocated_count = alloc_next;
        result_next.waking_up       = (alloc_next != '0);
    end

    assign life_we = cmd.execute && set_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.execute)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefill_mask_reg <= '0;
            decode_mask_reg  <= '0;
            p_ptr_reg        <= '0;
            d_ptr_reg        <= '0;
            awake_reg        <= '0;
            alloc_reg        <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                life_reg[i] <= ipp_pkg::ST_SLEEP;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ipp_pkg::REG_PREFILL_MASK)
                begin
                    prefill_mask_reg <= cfg_data;
                end
                else
                begin
                    decode_mask_reg <= cfg_data;
                end
            end
            if (cmd.execute)
            begin
                p_ptr_reg <= p_ptr_next;
                d_ptr_reg <= d_ptr_next;
                awake_reg <= awake_next;
                alloc_reg <= alloc_next;
            end
            if (life_we)
            begin
                life_reg[slot_idx] <= item_reg.req_state;
            end
        end
    end

    assign result = result_reg;

endmodule

FILE: rtl/ipp_checker.sv
// ipp_checker: port-level assertions for instance_pair_picker, bound below.
// Uses ipp_pkg for the result type.
module ipp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input ipp_pkg::out_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_done_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result strobe missing two cycles after accept");

    a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.awake_count <= result.allocated_count))
        else $error("awake count exceeds allocated count");

    a_waking: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.waking_up == (result.allocated_count != '0)) && !busy)
        else $error("waking_up inconsistent or strobe while busy");

endmodule

bind instance_pair_picker ipp_checker u_ipp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

FILE: tb/ipp_outcome_checker.sv
// ipp_outcome_checker: watches the request, result and config channels of the
// instance pair picker, predicts each result and compares it field by field.
// Depends on ipp_pkg for the payload structs and the state and function codes.
module ipp_outcome_checker
    import ipp_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  in_t               item,
    input  logic              done,
    input  out_t              result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [MASK_W-1:0] cfg_data,
    output int                mismatches,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]        life [SLOTS];
    logic [3:0]        prefill_ptr;
    logic [3:0]        decode_ptr;
    logic [CNT_W-1:0]  awake_n;
    logic [CNT_W-1:0]  alloc_n;
    logic [MASK_W-1:0] prefill_roles;
    logic [MASK_W-1:0] decode_roles;
    out_t              outcome_q [$];
    out_t              oldest;

    initial mismatches = 0;

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [4:0] got,
                               input logic [4:0] want);
        if (got !== want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - 1'b1;
    endfunction

    // rotated search for an awake member, ascending from the pointer
    function automatic bit find_awake(input logic [MASK_W-1:0] roles,
                                      input logic [3:0] from,
                                      output logic [3:0] hit);
        logic [3:0] s;
        hit = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            s = from + i[3:0];
            if (roles[s] && life[s] == ST_AWAKE)
            begin
                hit = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic out_t apply_slot_op(input in_t op);
        out_t       r;
        logic [1:0] cur;
        logic [3:0] ph;
        logic [3:0] dh;
        r = '0;
        cur = life[op.slot];
        if (op.func == FN_SET)
        begin
            case (op.req_state)
                ST_AWAKE:
                    if (cur == ST_ALLOC)
                    begin
                        life[op.slot] = ST_AWAKE;
                        awake_n = count_up(awake_n);
                        r.ok = 1'b1;
                    end
                ST_SLEEP:
                begin
                    if (cur == ST_AWAKE)
                    begin
                        awake_n = count_down(awake_n);
                        alloc_n = count_down(alloc_n);
                    end
                    else if (cur == ST_ALLOC)
                        alloc_n = count_down(alloc_n);
                    life[op.slot] = ST_SLEEP;
                    r.ok = 1'b1;
                end
                ST_ALLOC:
                    if (cur == ST_SLEEP)
                    begin
                        life[op.slot] = ST_ALLOC;
                        alloc_n = count_up(alloc_n);
                        r.ok = 1'b1;
                    end
                default:
                    if (cur == ST_AWAKE)
                    begin
                        life[op.slot] = ST_DRAIN;
                        awake_n = count_down(awake_n);
                        alloc_n = count_down(alloc_n);
                        r.ok = 1'b1;
                    end
            endcase
        end
        else if (op.func == FN_PICK && prefill_roles != '0 && decode_roles != '0)
        begin
            if (find_awake(prefill_roles, prefill_ptr, ph))
            begin
                if (find_awake(decode_roles, decode_ptr, dh))
                begin
                    r.ok = 1'b1;
                    r.prefill_slot = ph;
                    r.decode_slot = dh;
                    prefill_ptr = ph + 1'b1;
                    decode_ptr = dh + 1'b1;
                end
                else
                    prefill_ptr = ph;
            end
        end
        r.slot_status = life[op.slot];
        r.awake_count = awake_n;
        r.allocated_count = alloc_n;
        r.waking_up = (alloc_n != '0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                life[i] = ST_SLEEP;
            prefill_ptr = '0;
            decode_ptr = '0;
            awake_n = '0;
            alloc_n = '0;
            prefill_roles = '0;
            decode_roles = '0;
            outcome_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                    report("result transaction with nothing pending");
                else
                begin
                    oldest = outcome_q[0];
                    outcome_q.delete(0);
                    check_field("ok", 5'(result.ok), 5'(oldest.ok));
                    check_field("prefill_slot", 5'(result.prefill_slot),
                                5'(oldest.prefill_slot));
                    check_field("decode_slot", 5'(result.decode_slot),
                                5'(oldest.decode_slot));
                    check_field("slot_status", 5'(result.slot_status),
                                5'(oldest.slot_status));
                    check_field("awake_count", result.awake_count, oldest.awake_count);
                    check_field("allocated_count", result.allocated_count,
                                oldest.allocated_count);
                    check_field("waking_up", 5'(result.waking_up), 5'(oldest.waking_up));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_PREFILL_MASK)
                    prefill_roles = cfg_data;
                else
                    decode_roles = cfg_data;
            end
            if (start && !busy)
                outcome_q.insert(outcome_q.size(), apply_slot_op(item));
        end
        pending = outcome_q.size();
    end

endmodule

FILE: tb/instance_pair_picker_test.sv
// instance_pair_picker_test: drives directed and random transactions into the
// instance pair picker under several role-mask settings and idling phases.
// Depends on ipp_pkg, instance_pair_picker and ipp_outcome_checker.
module instance_pair_picker_test;
    import ipp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SLOTS       = 16;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         PHASE_OPS   = 205;
    localparam int         MAX_GAP     = 40;
    localparam logic [1:0] FN_SPARE    = 2'd3;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    in_t               item = '0;
    logic              done;
    out_t              result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = 1'b0;
    logic [MASK_W-1:0] cfg_data = '0;
    int                mismatches;
    int                pending;
    int                cycles = 0;
    int                idle_pct = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    instance_pair_picker #(.SLOTS(SLOTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ipp_outcome_checker #(.SLOTS(SLOTS)) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one request transaction, with a random hold-off before it
    task automatic send_op(input in_t op);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= op;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic op(input logic [1:0] func, input logic [3:0] slot,
                      input logic [1:0] st);
        in_t t;
        t.func = func;
        t.slot = slot;
        t.req_state = st;
        send_op(t);
    endtask

    // stop issuing and wait until every result has come back
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [MASK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_t random_op();
        in_t t;
        int  r;
        r = $urandom_range(99);
        if (r < 35)
            t.func = FN_PICK;
        else if (r < 80)
            t.func = FN_SET;
        else if (r < 95)
            t.func = FN_READ;
        else
            t.func = FN_SPARE;
        t.slot = 4'($urandom_range(SLOTS - 1));
        // lean towards the forward transitions so slots get woken
        r = $urandom_range(99);
        if (r < 35)
            t.req_state = ST_ALLOC;
        else if (r < 70)
            t.req_state = ST_AWAKE;
        else if (r < 85)
            t.req_state = ST_SLEEP;
        else
            t.req_state = ST_DRAIN;
        return t;
    endfunction

    initial
    begin
        logic [MASK_W-1:0] pm;
        logic [MASK_W-1:0] dm;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refused and accepted transitions, empty roles, partial picks
        op(FN_PICK, 4'd0, ST_SLEEP);
        op(FN_READ, 4'd0, ST_SLEEP);
        op(FN_SPARE, 4'd15, ST_DRAIN);
        op(FN_SET, 4'd0, ST_AWAKE);
        op(FN_SET, 4'd0, ST_DRAIN);
        op(FN_SET, 4'd0, ST_SLEEP);
        op(FN_SET, 4'd0, ST_ALLOC);
        op(FN_SET, 4'd0, ST_ALLOC);
        op(FN_SET, 4'd0, ST_AWAKE);
        op(FN_SET, 4'd15, ST_ALLOC);
        op(FN_SET, 4'd15, ST_AWAKE);
        op(FN_PICK, 4'd15, ST_SLEEP);
        settle();
        write_reg(REG_PREFILL_MASK, 16'h0001);
        write_reg(REG_DECODE_MASK, 16'h8000);
        @(posedge clk);
        op(FN_PICK, 4'd0, ST_SLEEP);
        op(FN_PICK, 4'd15, ST_SLEEP);
        op(FN_SET, 4'd15, ST_DRAIN);
        op(FN_PICK, 4'd0, ST_SLEEP);
        op(FN_SET, 4'd15, ST_SLEEP);
        op(FN_SET, 4'd15, ST_AWAKE);
        op(FN_SET, 4'd0, ST_SLEEP);
        op(FN_SET, 4'd3, ST_ALLOC);
        op(FN_SET, 4'd3, ST_SLEEP);
        op(FN_PICK, 4'd3, ST_SLEEP);
        op(FN_READ, 4'd15, ST_SLEEP);

        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            pm = 16'($urandom_range(16'hFFFF));
            dm = 16'($urandom_range(16'hFFFF));
            case (phase)
                0: begin pm = 16'hFFFF; dm = 16'hFFFF; end
                1: dm = ~pm;
                2: pm = '0;
                4: begin pm = 16'h00FF; dm = 16'hFF00; end
                5:
                begin
                    pm = 16'h0001 << $urandom_range(15);
                    dm = 16'h8000 >> $urandom_range(15);
                end
                6: dm = '0;
                default: ;
            endcase
            write_reg(REG_PREFILL_MASK, pm);
            write_reg(REG_DECODE_MASK, dm);
            @(posedge clk);
            case (phase % 4)
                1: idle_pct = 74;
                3: idle_pct = 6;
                default: idle_pct = 0;
            endcase
            repeat (PHASE_OPS)
                send_op(random_op());
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
